/* sv/pffa_pkg.sv */
package pffa_pkg;

    // fixed field widths
    localparam int ADDR_W    = 40;
    localparam int RES_W     = 11;
    localparam int CNT_OUT_W = 11;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BASE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_PAGES = 1'd1;

    // reset value of the base address register
    localparam logic [ADDR_W-1:0] BASE_RESET = 40'h00_8000_0000;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INIT  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EXHAUSTED   = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_BAD_ADDR    = 2'd3
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_ALLOC,
        S_FREE_CHK,
        S_FREE_WR,
        S_RESP
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic    accept;
        logic    clear_step;
        logic    init_start;
        logic    init_step;
        logic    alloc_rd;
        logic    alloc_commit;
        logic    free_sub;
        logic    free_rd;
        logic    free_commit;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic sweep_last;
        logic list_empty;
        logic free_bad;
        logic page_in_use;
    } t_dp_stat;

endpackage

/* sv/pffa_dp.sv */
module pffa_dp
    import pffa_pkg::*;
#(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic [ADDR_W-1:0]    i_free_address,
    output logic [1:0]           o_status,
    output logic [ADDR_W-1:0]    o_page_address,
    output logic [CNT_OUT_W-1:0] o_free_pages
);

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int CMP_W = (CNT_W > RES_W) ? CNT_W : RES_W;
    localparam int HI_W  = ADDR_W - PAGE_SHIFT;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);

    // configuration
    logic [ADDR_W-1:0] r_base;
    logic [RES_W-1:0]  r_reserved;

    // list control
    logic [CNT_W-1:0] r_keep, n_keep;
    logic [IDX_W-1:0] r_sweep;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    // working payload
    logic              r_lt;
    logic [ADDR_W-1:0] r_diff;
    logic [IDX_W-1:0]  r_ring_q;
    logic              r_bit_q;
    t_status           r_status;
    logic [ADDR_W-1:0] r_page_addr;

    // result word
    t_status              r_out_status;
    logic [ADDR_W-1:0]    r_out_addr;
    logic [CNT_OUT_W-1:0] r_out_free;

    // storage
    logic [IDX_W-1:0] r_ring [NUM_PAGES];
    logic             r_bits [NUM_PAGES];

    logic [IDX_W-1:0] w_free_idx;
    logic             w_sweep_reserved;
    logic             w_ring_we;
    logic [IDX_W-1:0] w_ring_wd;
    logic             w_bit_we;
    logic [IDX_W-1:0] w_bit_wa;
    logic             w_bit_wd;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : IDX_W'(p + 1'b1);
    endfunction

    // reserved count clamped to the number of pages
    assign n_keep = (CMP_W'(r_reserved) > CMP_W'(NUM_PAGES)) ?
                    CNT_W'(NUM_PAGES) : CNT_W'(r_reserved);

    assign w_free_idx       = r_diff[PAGE_SHIFT +: IDX_W];
    assign w_sweep_reserved = CNT_W'(r_sweep) < r_keep;

    // ring write port
    assign w_ring_we = (i_cmd.init_step && !w_sweep_reserved) || i_cmd.free_commit;
    assign w_ring_wd = i_cmd.init_step ? r_sweep : w_free_idx;

    // in-use bitmap write port
    always_comb begin
        w_bit_we = 1'b0;
        w_bit_wa = r_sweep;
        w_bit_wd = 1'b1;
        if (i_cmd.clear_step) begin
            w_bit_we = 1'b1;
        end else if (i_cmd.init_step) begin
            w_bit_we = 1'b1;
            w_bit_wd = w_sweep_reserved;
        end else if (i_cmd.alloc_commit) begin
            w_bit_we = 1'b1;
            w_bit_wa = r_ring_q;
        end else if (i_cmd.free_commit) begin
            w_bit_we = 1'b1;
            w_bit_wa = w_free_idx;
            w_bit_wd = 1'b0;
        end
    end

    // free ring memory
    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[r_tail] <= w_ring_wd;
        end
        if (i_cmd.alloc_rd) begin
            r_ring_q <= r_ring[r_head];
        end
    end

    // in-use bitmap memory
    always_ff @(posedge i_clk) begin
        if (w_bit_we) begin
            r_bits[w_bit_wa] <= w_bit_wd;
        end
        if (i_cmd.free_rd) begin
            r_bit_q <= r_bits[w_free_idx];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= BASE_RESET;
            r_reserved <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MEMORY_BASE:    r_base     <= i_cfg_data;
                CFG_RESERVED_PAGES: r_reserved <= i_cfg_data[RES_W-1:0];
                default: ;
            endcase
        end
    end

    // pointers, count and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep  <= '0;
            r_sweep <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.init_start) begin
            r_keep  <= n_keep;
            r_sweep <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.clear_step || i_cmd.init_step) begin
                r_sweep <= f_next(r_sweep);
            end
            if (w_ring_we) begin
                r_tail  <= f_next(r_tail);
                r_count <= CNT_W'(r_count + 1'b1);
            end
            if (i_cmd.alloc_commit) begin
                r_head  <= f_next(r_head);
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    // request payload and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status    <= ST_OK;
            r_page_addr <= '0;
        end
        if (i_cmd.free_sub) begin
            r_lt   <= i_free_address < r_base;
            r_diff <= i_free_address - r_base;
        end
        if (i_cmd.alloc_commit) begin
            r_page_addr <= r_base + (ADDR_W'(r_ring_q) << PAGE_SHIFT);
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_addr   <= r_page_addr;
            r_out_free   <= CNT_OUT_W'(r_count);
        end
    end

    // status back to the controller
    assign o_stat.sweep_last  = r_sweep == LAST_IDX;
    assign o_stat.list_empty  = r_count == '0;
    assign o_stat.free_bad    = r_lt || (r_diff[ADDR_W-1:PAGE_SHIFT] >= HI_W'(NUM_PAGES));
    assign o_stat.page_in_use = r_bit_q;

    assign o_status       = r_out_status;
    assign o_page_address = r_out_addr;
    assign o_free_pages   = r_out_free;

endmodule

/* sv/pffa_ctrl.sv */
module pffa_ctrl
    import pffa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_dp_cmd          o_cmd,
    input  t_dp_stat         i_stat
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.status = ST_OK;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (t_req'(i_req_type))
                        REQ_INIT: begin
                            o_cmd.init_start = 1'b1;
                            n_state = S_INIT;
                        end
                        REQ_ALLOC: begin
                            if (i_stat.list_empty) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = ST_EXHAUSTED;
                                n_state = S_RESP;
                            end else begin
                                o_cmd.alloc_rd = 1'b1;
                                n_state = S_ALLOC;
                            end
                        end
                        REQ_FREE: begin
                            o_cmd.free_sub = 1'b1;
                            n_state = S_FREE_CHK;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_RESP;
                end
            end
            S_ALLOC: begin
                o_cmd.alloc_commit = 1'b1;
                n_state = S_RESP;
            end
            S_FREE_CHK: begin
                if (i_stat.free_bad) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_BAD_ADDR;
                    n_state = S_RESP;
                end else begin
                    o_cmd.free_rd = 1'b1;
                    n_state = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                if (i_stat.page_in_use) begin
                    o_cmd.free_commit = 1'b1;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_DOUBLE_FREE;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                // wait for the result slot to be free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result word held until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* sv/page_frame_free_list_allocator.sv */
// Page frame allocator with a FIFO free list of page indices and an in-use bitmap, both in
// single-port-write memories of NUM_PAGES entries. After reset the block sweeps all pages,
// setting every in-use bit (no request is taken then; configuration writes are). Until the
// first init request the list is empty and every page counts as in use. Steps per request,
// from acceptance to the result word: alloc: ring read, bitmap update, result (no ring read
// or update when the list is empty); free: address subtract, bitmap read, update if the
// page is in use, result (no bitmap read or update for an address outside memory); init:
// one page per cycle through the sweep counter, then the result; an unused request type:
// straight to the result. The next request is taken once the controller is idle again,
// even while the previous result word still waits at the output register.
module page_frame_free_list_allocator
    import pffa_pkg::*;
#(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [ADDR_W-1:0]    i_free_address,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [ADDR_W-1:0]    o_page_address,
    output logic [CNT_OUT_W-1:0] o_free_pages,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    pffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // list storage and address math
    pffa_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_free_address (i_free_address),
        .o_status       (o_status),
        .o_page_address (o_page_address),
        .o_free_pages   (o_free_pages)
    );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import pffa_pkg::*;

    localparam int NUM_PAGES       = 1024;
    localparam int PAGE_SHIFT      = 12;
    localparam int IDX_W           = $clog2(NUM_PAGES);
    localparam int LONG_HOLD       = 300;
    localparam int RANDOM_REQUESTS = 1000;

    // the one request code the package leaves unnamed
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // one result word as the block reports it
    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_W-1:0]    page;
        logic [CNT_OUT_W-1:0] count;
    } t_page_word;

    // one row of the directed table: a request or a register write
    typedef struct packed {
        logic                 is_write;
        logic [REQ_W-1:0]     req;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [ADDR_W-1:0]    value;
        logic                 typed;
        t_page_word           want;
    } t_step_row;

    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic [REQ_W-1:0]     i_req_type     = '0;
    logic [ADDR_W-1:0]    i_free_address = '0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b1;
    logic [1:0]           o_status;
    logic [ADDR_W-1:0]    o_page_address;
    logic [CNT_OUT_W-1:0] o_free_pages;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [ADDR_W-1:0]    i_cfg_data     = '0;

    page_frame_free_list_allocator #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_free_address (i_free_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_page_address (o_page_address),
        .o_free_pages   (o_free_pages),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // allocator shadow: registers, free ring, in-use bits
    logic [ADDR_W-1:0] base_reg;
    logic [RES_W-1:0]  reserve_reg;
    logic [IDX_W-1:0]  frame_ring [NUM_PAGES];
    bit                frame_taken [NUM_PAGES];
    logic [IDX_W-1:0]  ring_rd;
    logic [IDX_W-1:0]  ring_wr;
    int                frames_free;
    logic [IDX_W-1:0]  held_frames [$];

    // words still owed by the block, oldest first
    t_page_word        owed_words [$];
    int                words_owed;

    // handshake bookkeeping shared by the drivers
    bit                offering;
    bit                cfg_writing;
    int                next_gap;
    bit                quiet_in;
    bit                quiet_out;
    bit                long_hold_armed;

    // run tallies
    int                mismatches;
    int                words_checked;
    int                reg_writes;
    int                inits;
    int                allocs;
    int                frees;
    int                exhausted;
    int                double_frees;
    int                bad_addresses;
    int                unused_reqs;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #5_000_000;
        $display("timeout with %0d words still owed", words_owed);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] any_address();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    // physical address of a frame, wrapping at the address width
    function automatic logic [ADDR_W-1:0] frame_address(input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] span;
        span = '0;
        span[IDX_W-1:0] = idx;
        return base_reg + (span << PAGE_SHIFT);
    endfunction

    // apply one request to the shadow and work out its result word
    function automatic void predict_request(input logic [REQ_W-1:0] req,
                                            input logic [ADDR_W-1:0] addr,
                                            output t_page_word word);
        logic [ADDR_W-1:0] offset;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W:0]    pg;
        int                keep;
        word = '0;
        word.status = ST_OK;
        case (req)
            REQ_INIT: begin
                keep = int'(reserve_reg);
                if (keep > NUM_PAGES) keep = NUM_PAGES;
                ring_rd = '0;
                ring_wr = '0;
                frames_free = 0;
                held_frames.delete();
                for (pg = '0; pg < NUM_PAGES; pg++) begin
                    frame_taken[pg[IDX_W-1:0]] = (pg < keep);
                    if (pg >= keep) begin
                        frame_ring[ring_wr] = pg[IDX_W-1:0];
                        ring_wr = ring_wr + 1'b1;
                        frames_free++;
                    end
                end
                inits++;
            end
            REQ_ALLOC: begin
                if (frames_free == 0) begin
                    word.status = ST_EXHAUSTED;
                    exhausted++;
                end else begin
                    idx = frame_ring[ring_rd];
                    ring_rd = ring_rd + 1'b1;
                    frames_free--;
                    frame_taken[idx] = 1'b1;
                    held_frames.push_back(idx);
                    word.page = frame_address(idx);
                    allocs++;
                end
            end
            REQ_FREE: begin
                offset = addr - base_reg;
                if (addr < base_reg || (offset >> PAGE_SHIFT) >= NUM_PAGES) begin
                    word.status = ST_BAD_ADDR;
                    bad_addresses++;
                end else begin
                    idx = offset[PAGE_SHIFT +: IDX_W];
                    if (!frame_taken[idx]) begin
                        word.status = ST_DOUBLE_FREE;
                        double_frees++;
                    end else begin
                        frame_taken[idx] = 1'b0;
                        frame_ring[ring_wr] = idx;
                        ring_wr = ring_wr + 1'b1;
                        frames_free++;
                        frees++;
                    end
                end
            end
            default: begin
                unused_reqs++;
            end
        endcase
        word.count = frames_free[CNT_OUT_W-1:0];
    endfunction

    // drop valid unless the next word follows at once
    task automatic stop_offering();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // register write, only once every owed word has come back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [ADDR_W-1:0] data);
        stop_offering();
        wait (words_owed == 0);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        cfg_writing = 1'b1;
        @(posedge i_clk);
        if (sel == CFG_MEMORY_BASE) base_reg = data;
        else reserve_reg = data[RES_W-1:0];
        reg_writes++;
    endtask

    // offer one request word and record what it should produce
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                                input logic typed, input t_page_word typed_word);
        t_page_word predicted;
        if (cfg_writing) begin
            i_cfg_we <= 1'b0;
            cfg_writing = 1'b0;
        end
        repeat (next_gap) @(posedge i_clk);
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_free_address <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        predict_request(req, addr, predicted);
        owed_words.push_back(typed ? typed_word : predicted);
        words_owed++;
        next_gap = quiet_in ? 0 : $urandom_range(0, 9);
        if (next_gap > 0) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end else begin
            offering = 1'b1;
        end
    endtask

    // result side: random stall per word, one long hold when armed
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (long_hold_armed) begin
                    stall_left = LONG_HOLD;
                    long_hold_armed = 1'b0;
                end else begin
                    stall_left = quiet_out ? 0 : $urandom_range(0, 9);
                end
                if (stall_left > 0) i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) i_out_ready <= 1'b1;
            end
        end
    end

    // compare each result word with the oldest owed one
    always @(posedge i_clk) begin : check_words
        t_page_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_words.size() == 0) begin
                $error("result word with none owed: status %0d, page %h, count %0d",
                       o_status, o_page_address, o_free_pages);
                mismatches++;
            end else begin
                want = owed_words.pop_front();
                words_owed--;
                words_checked++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_page_address !== want.page) begin
                    $error("page_address: expected %h, actual %h", want.page, o_page_address);
                    mismatches++;
                end
                if (o_free_pages !== want.count) begin
                    $error("free_pages: expected %0d, actual %0d", want.count, o_free_pages);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_step_row         directed_rows [28];
        int                pick;
        int                alloc_pct;
        int                burst;
        int                random_sent;
        int                pos;
        int                phases;
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  idx;

        // state out of reset: no list, every frame in use
        base_reg    = BASE_RESET;
        reserve_reg = '0;
        ring_rd     = '0;
        ring_wr     = '0;
        frames_free = 0;
        foreach (frame_taken[i]) frame_taken[i] = 1'b1;
        next_gap    = 0;

        // edge cases first; typed expectations where they are obvious
        directed_rows = '{
            // before init: empty list, frees of in-range pages go through
            '{1'b0, REQ_ALLOC,  CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_EXHAUSTED, 40'h0, 11'd0}},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_BAD_ADDR, 40'h0, 11'd0}},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'hFF_FFFF_FFFF, 1'b1,
              '{ST_BAD_ADDR, 40'h0, 11'd0}},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'h00_8040_0000, 1'b1,
              '{ST_BAD_ADDR, 40'h0, 11'd0}},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'h00_803F_FFFF, 1'b1,
              '{ST_OK, 40'h0, 11'd1}},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'h00_803F_F000, 1'b1,
              '{ST_DOUBLE_FREE, 40'h0, 11'd1}},
            '{1'b0, REQ_ALLOC,  CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_OK, 40'h00_803F_F000, 11'd0}},
            // full list, then alloc / free round trips
            '{1'b0, REQ_INIT,   CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_OK, 40'h0, 11'd1024}},
            '{1'b0, REQ_ALLOC,  CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_OK, 40'h00_8000_0000, 11'd1023}},
            '{1'b0, REQ_ALLOC,  CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_OK, 40'h00_8000_1000, 11'd1022}},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'h00_8000_1FFF, 1'b1,
              '{ST_OK, 40'h0, 11'd1023}},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'h00_8000_1000, 1'b1,
              '{ST_DOUBLE_FREE, 40'h0, 11'd1023}},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'h00_8000_5000, 1'b0, '0},
            '{1'b0, REQ_UNUSED, CFG_MEMORY_BASE, 40'hFF_FFFF_FFFF, 1'b1,
              '{ST_OK, 40'h0, 11'd1023}},
            // oversized reserve keeps every frame
            '{1'b1, REQ_INIT,   CFG_RESERVED_PAGES, 40'd2047, 1'b0, '0},
            '{1'b0, REQ_INIT,   CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_OK, 40'h0, 11'd0}},
            '{1'b0, REQ_ALLOC,  CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_EXHAUSTED, 40'h0, 11'd0}},
            // top-of-range base, unaligned free, wrapped frame address
            '{1'b1, REQ_INIT,   CFG_MEMORY_BASE, 40'hFF_FFFF_F000, 1'b0, '0},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'hFF_FFFF_FFFF, 1'b1,
              '{ST_OK, 40'h0, 11'd1}},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_BAD_ADDR, 40'h0, 11'd1}},
            '{1'b1, REQ_INIT,   CFG_RESERVED_PAGES, 40'd1023, 1'b0, '0},
            '{1'b0, REQ_INIT,   CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_OK, 40'h0, 11'd1}},
            '{1'b0, REQ_ALLOC,  CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_OK, 40'h00_003F_E000, 11'd0}},
            '{1'b0, REQ_ALLOC,  CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_EXHAUSTED, 40'h0, 11'd0}},
            // zero base, no reserve
            '{1'b1, REQ_INIT,   CFG_MEMORY_BASE, 40'h0, 1'b0, '0},
            '{1'b1, REQ_INIT,   CFG_RESERVED_PAGES, 40'd0, 1'b0, '0},
            '{1'b0, REQ_INIT,   CFG_MEMORY_BASE, 40'h0, 1'b1, '{ST_OK, 40'h0, 11'd1024}},
            '{1'b0, REQ_FREE,   CFG_MEMORY_BASE, 40'h0, 1'b0, '0}
        };

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_write) begin
                write_reg(directed_rows[r].reg_sel, directed_rows[r].value);
            end else begin
                send_request(directed_rows[r].req, directed_rows[r].value,
                             directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // random phases: new register setting, init, then a mix of requests
        random_sent = 0;
        phases = 0;
        while (random_sent < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 4))
                0: addr = '0;
                1: addr = 40'hFF_FFFF_F000;
                2: addr = BASE_RESET;
                3: addr = any_address() & ~40'hFFF;
                default: addr = any_address();
            endcase
            write_reg(CFG_MEMORY_BASE, addr);
            case ($urandom_range(0, 4))
                0: addr = 40'd0;
                1: addr = 40'd1024;
                2: addr = ADDR_W'($urandom_range(1025, 2047));
                3: addr = ADDR_W'($urandom_range(1000, 1024));
                default: addr = ADDR_W'($urandom_range(0, 1024));
            endcase
            write_reg(CFG_RESERVED_PAGES, addr);

            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            alloc_pct = $urandom_range(25, 70);
            send_request(REQ_INIT, any_address(), 1'b0, '0);
            if (phases == 2) long_hold_armed = 1'b1;

            burst = $urandom_range(40, 120);
            for (int n = 0; n < burst; n++) begin
                pick = $urandom_range(0, 99);
                addr = any_address();
                if (pick < alloc_pct) begin
                    req = REQ_ALLOC;
                end else if (pick < 90 && held_frames.size() > 0) begin
                    // give back a frame we hold, anywhere inside it
                    req = REQ_FREE;
                    pos = $urandom_range(0, held_frames.size() - 1);
                    idx = held_frames[pos];
                    held_frames.delete(pos);
                    addr = frame_address(idx) + ADDR_W'($urandom_range(0, 4095));
                end else if (pick < 94) begin
                    // any frame: reserved, free or held
                    req = REQ_FREE;
                    idx = IDX_W'($urandom_range(0, NUM_PAGES - 1));
                    addr = frame_address(idx) + ADDR_W'($urandom_range(0, 4095));
                end else if (pick < 97) begin
                    // outside managed memory
                    req = REQ_FREE;
                    case ($urandom_range(0, 2))
                        0: if (base_reg != 0) addr = addr % base_reg;
                        1: addr = base_reg + ADDR_W'(NUM_PAGES << PAGE_SHIFT)
                                  + ADDR_W'($urandom_range(0, 'hFFFFF));
                        default: ;
                    endcase
                end else if (pick < 99) begin
                    req = REQ_UNUSED;
                end else begin
                    req = REQ_INIT;
                end
                send_request(req, addr, 1'b0, '0);
                random_sent++;
            end
            phases++;
        end

        // drain
        stop_offering();
        wait (words_owed == 0);
        repeat (20) @(posedge i_clk);

        $display("%0d words checked over %0d register writes: %0d inits, %0d allocs, %0d frees",
                 words_checked, reg_writes, inits, allocs, frees);
        $display("refused: %0d exhausted, %0d double frees, %0d bad addresses, %0d unused codes",
                 exhausted, double_frees, bad_addresses, unused_reqs);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
